/* rtl/glu_pkg.sv */
// Shared types, constants and the microcode table of the GCD/LCM unit.
`default_nettype none
package glu_pkg;

    localparam int unsigned OPER_W = 32;
    localparam int unsigned GCD_W  = 32;
    localparam int unsigned LCM_W  = 64;
    localparam int unsigned STEP_W = 4;

    // Branch conditions; the two wait kinds hold the step and suppress its actions.
    typedef enum logic [2:0] {
        C_NEXT     = 3'd0,
        C_JUMP     = 3'd1,
        C_Y_ZERO   = 3'd2,
        C_X_ZERO   = 3'd3,
        C_CNT_MORE = 3'd4,
        C_WAIT_IN  = 3'd5,
        C_WAIT_OUT = 3'd6
    } t_cond;

    typedef enum logic {
        SRC_EUCLID = 1'b0,
        SRC_LCM    = 1'b1
    } t_div_src;

    typedef struct packed {
        logic              ld_in;
        logic              div_init;
        t_div_src          div_src;
        logic              div_step;
        logic              swap;
        logic              mul;
        logic              emit;
        t_cond             cond;
        logic [STEP_W-1:0] target;
    } t_ctl;

    typedef struct packed {
        logic in_valid;
        logic out_busy;
        logic y_zero;
        logic x_zero;
        logic cnt_last;
    } t_status;

    localparam logic [STEP_W-1:0] S_FETCH    = 4'd0;
    localparam logic [STEP_W-1:0] S_TEST     = 4'd1;
    localparam logic [STEP_W-1:0] S_EDIV     = 4'd2;
    localparam logic [STEP_W-1:0] S_ELOOP    = 4'd3;
    localparam logic [STEP_W-1:0] S_SWAP     = 4'd4;
    localparam logic [STEP_W-1:0] S_GCHK     = 4'd5;
    localparam logic [STEP_W-1:0] S_LDIV     = 4'd6;
    localparam logic [STEP_W-1:0] S_LLOOP    = 4'd7;
    localparam logic [STEP_W-1:0] S_MUL      = 4'd8;
    localparam logic [STEP_W-1:0] S_EMIT     = 4'd15;

    localparam t_ctl CTL_NOP = '{
        ld_in: 1'b0, div_init: 1'b0, div_src: SRC_EUCLID, div_step: 1'b0,
        swap: 1'b0, mul: 1'b0, emit: 1'b0, cond: C_JUMP, target: S_FETCH
    };

    // Emit sits at the last address so that falling through wraps to fetch.
    function automatic t_ctl rom_word(input logic [STEP_W-1:0] pc);
        t_ctl w;
        w = CTL_NOP;
        unique case (pc)
            S_FETCH: begin
                w.ld_in = 1'b1; w.cond = C_WAIT_IN; w.target = S_FETCH;
            end
            S_TEST: begin
                w.cond = C_Y_ZERO; w.target = S_GCHK;
            end
            S_EDIV: begin
                w.div_init = 1'b1; w.div_src = SRC_EUCLID; w.cond = C_NEXT;
            end
            S_ELOOP: begin
                w.div_step = 1'b1; w.cond = C_CNT_MORE; w.target = S_ELOOP;
            end
            S_SWAP: begin
                w.swap = 1'b1; w.cond = C_JUMP; w.target = S_TEST;
            end
            S_GCHK: begin
                w.cond = C_X_ZERO; w.target = S_EMIT;
            end
            S_LDIV: begin
                w.div_init = 1'b1; w.div_src = SRC_LCM; w.cond = C_NEXT;
            end
            S_LLOOP: begin
                w.div_step = 1'b1; w.cond = C_CNT_MORE; w.target = S_LLOOP;
            end
            S_MUL: begin
                w.mul = 1'b1; w.cond = C_JUMP; w.target = S_EMIT;
            end
            S_EMIT: begin
                w.emit = 1'b1; w.cond = C_WAIT_OUT; w.target = S_EMIT;
            end
            default: begin
                w = CTL_NOP;
            end
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

/* rtl/glu_seq.sv */
// Microcode sequencer: step counter, control table and branch logic.
`default_nettype none
module glu_seq (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire glu_pkg::t_status i_status,
    output glu_pkg::t_ctl        o_ctl,
    output logic                 o_act
);
    import glu_pkg::*;

    logic [STEP_W-1:0] r_pc;
    logic [STEP_W-1:0] n_pc;
    t_ctl              w_ctl;
    logic              w_take;

    assign w_ctl = rom_word(r_pc);

    always_comb begin
        unique case (w_ctl.cond)
            C_NEXT:     w_take = 1'b0;
            C_JUMP:     w_take = 1'b1;
            C_Y_ZERO:   w_take = i_status.y_zero;
            C_X_ZERO:   w_take = i_status.x_zero;
            C_CNT_MORE: w_take = !i_status.cnt_last;
            C_WAIT_IN:  w_take = !i_status.in_valid;
            C_WAIT_OUT: w_take = i_status.out_busy;
            default:    w_take = 1'b1;
        endcase
    end

    // A waiting step does nothing until its condition clears.
    always_comb begin
        if ((w_ctl.cond == C_WAIT_IN) || (w_ctl.cond == C_WAIT_OUT)) begin
            o_act = !w_take;
        end else begin
            o_act = 1'b1;
        end
    end

    assign n_pc  = w_take ? w_ctl.target : r_pc + STEP_W'(1);
    assign o_ctl = w_ctl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= S_FETCH;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule
`default_nettype wire

/* rtl/glu_dp.sv */
// Datapath: operand registers, shift-subtract divider, multiplier, result register.
`default_nettype none
module glu_dp #(
    parameter int unsigned WIDTH = 32
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire glu_pkg::t_ctl                i_ctl,
    input  wire logic                         i_act,
    input  wire logic [glu_pkg::OPER_W-1:0]   i_a,
    input  wire logic [glu_pkg::OPER_W-1:0]   i_b,
    input  wire logic                         i_out_ready,
    output logic                              o_out_valid,
    output logic [glu_pkg::GCD_W-1:0]         o_gcd,
    output logic [glu_pkg::LCM_W-1:0]         o_lcm,
    output logic                              o_undef,
    output logic                              o_y_zero,
    output logic                              o_x_zero,
    output logic                              o_cnt_last
);
    import glu_pkg::*;

    localparam int unsigned CNT_W = $clog2(WIDTH + 1);

    logic [WIDTH-1:0]   r_a0, r_b0, r_x, r_y, r_rem, r_quo, r_div;
    logic [CNT_W-1:0]   r_cnt;
    logic [2*WIDTH-1:0] r_prod;
    logic               r_out_valid;
    logic [GCD_W-1:0]   r_out_gcd;
    logic [LCM_W-1:0]   r_out_lcm;
    logic               r_out_undef;

    logic [WIDTH:0]     w_trial;
    logic [WIDTH:0]     w_diff;
    logic [2*WIDTH-1:0] w_prod;
    logic               w_emit;

    assign w_trial = {r_rem, r_quo[WIDTH-1]};
    assign w_diff  = w_trial - {1'b0, r_div};
    assign w_prod  = (2*WIDTH)'(r_quo) * (2*WIDTH)'(r_b0);
    assign w_emit  = i_act && i_ctl.emit;

    always_ff @(posedge i_clk) begin
        if (i_act) begin
            if (i_ctl.ld_in) begin
                r_a0   <= i_a[WIDTH-1:0];
                r_b0   <= i_b[WIDTH-1:0];
                r_x    <= i_a[WIDTH-1:0];
                r_y    <= i_b[WIDTH-1:0];
                r_prod <= '0;
            end
            if (i_ctl.div_init) begin
                r_rem <= '0;
                r_cnt <= CNT_W'(WIDTH);
                if (i_ctl.div_src == SRC_LCM) begin
                    r_quo <= r_a0;
                    r_div <= r_x;
                end else begin
                    r_quo <= r_x;
                    r_div <= r_y;
                end
            end
            // One quotient bit per step; the remainder stays below the divisor.
            if (i_ctl.div_step) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (!w_diff[WIDTH]) begin
                    r_rem <= w_diff[WIDTH-1:0];
                    r_quo <= {r_quo[WIDTH-2:0], 1'b1};
                end else begin
                    r_rem <= w_trial[WIDTH-1:0];
                    r_quo <= {r_quo[WIDTH-2:0], 1'b0};
                end
            end
            if (i_ctl.swap) begin
                r_x <= r_y;
                r_y <= r_rem;
            end
            if (i_ctl.mul) begin
                r_prod <= w_prod;
            end
        end
        if (w_emit) begin
            r_out_gcd   <= GCD_W'(r_x);
            r_out_lcm   <= LCM_W'(r_prod);
            r_out_undef <= (r_x == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_gcd       = r_out_gcd;
    assign o_lcm       = r_out_lcm;
    assign o_undef     = r_out_undef;
    assign o_y_zero    = (r_y == '0);
    assign o_x_zero    = (r_x == '0);
    assign o_cnt_last  = (r_cnt == CNT_W'(1));

endmodule
`default_nettype wire

/* rtl/gcd_lcm_unit.sv */
// Top level of the GCD/LCM unit: stream ports, sequencer and datapath.
//
// Input channel (i_s_*): one item holds two unsigned operands; only their
// low WIDTH bits are used. Output channel (o_m_*): one item per input, with
// the greatest common divisor, the exact least common multiple and a flag
// set when both operands are zero (divisor 0, multiple 0).
// An item is taken only when the unit is at its fetch step; it then works
// on that item alone. Each remainder step of Euclid's iteration is a test,
// a division set-up, one quotient bit per cycle in the shared divider, and
// a swap; the multiple adds a divisor check, a second division by the
// divisor and a multiply step. Fetch, the final test and emit come on top.
// Both operands zero is the shortest case; adjacent large Fibonacci
// numbers give the longest remainder chain.
// The result waits in an output register; the next item is accepted while
// it waits, and the unit holds at its emit step only if a new result is
// ready before the receiver has taken the old one.
// Synchronous reset returns the sequencer to fetch and empties the output;
// no item is taken while reset is held.
`default_nettype none
module gcd_lcm_unit #(
    parameter int unsigned WIDTH = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [63:0] i_s_tdata,   // [31:0] operand_a, [63:32] operand_b
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [95:0]      o_m_tdata,   // [31:0] gcd_value, [95:32] lcm_value
    output logic [0:0]       o_m_tuser    // [0] lcm_undefined
);
    import glu_pkg::*;

    t_ctl             w_ctl;
    t_status          w_status;
    logic             w_act;
    logic             w_out_valid;
    logic [GCD_W-1:0] w_gcd;
    logic [LCM_W-1:0] w_lcm;
    logic             w_undef;
    logic             w_y_zero;
    logic             w_x_zero;
    logic             w_cnt_last;

    assign w_status = '{
        in_valid: i_s_tvalid,
        out_busy: w_out_valid && !i_m_tready,
        y_zero:   w_y_zero,
        x_zero:   w_x_zero,
        cnt_last: w_cnt_last
    };

    glu_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (w_status),
        .o_ctl    (w_ctl),
        .o_act    (w_act)
    );

    glu_dp #(
        .WIDTH (WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ctl),
        .i_act       (w_act),
        .i_a         (i_s_tdata[OPER_W-1:0]),
        .i_b         (i_s_tdata[2*OPER_W-1:OPER_W]),
        .i_out_ready (i_m_tready),
        .o_out_valid (w_out_valid),
        .o_gcd       (w_gcd),
        .o_lcm       (w_lcm),
        .o_undef     (w_undef),
        .o_y_zero    (w_y_zero),
        .o_x_zero    (w_x_zero),
        .o_cnt_last  (w_cnt_last)
    );

    assign o_s_tready = (w_ctl.cond == C_WAIT_IN) && i_rst_n;
    assign o_m_tvalid = w_out_valid;
    assign o_m_tdata  = {w_lcm, w_gcd};
    assign o_m_tuser  = w_undef;

endmodule
`default_nettype wire

/* dv/gcd_lcm_checker.sv */
`timescale 1ns / 1ps
// Checker of the GCD/LCM unit: predicts each result from the accepted operands and compares.
module gcd_lcm_checker #(
    parameter int unsigned WIDTH = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    input  wire logic        i_s_tready,
    input  wire logic [63:0] i_s_tdata,   // [31:0] operand_a, [63:32] operand_b
    input  wire logic        i_m_tvalid,
    input  wire logic        i_m_tready,
    input  wire logic [95:0] i_m_tdata,   // [31:0] gcd_value, [95:32] lcm_value
    input  wire logic [0:0]  i_m_tuser,   // [0] lcm_undefined
    output int               o_fail_count,
    output int               o_pending
);
    import glu_pkg::*;

    localparam int unsigned REPORT_LIMIT = 10;
    localparam logic [63:0] OPERAND_MASK = (64'd1 << WIDTH) - 64'd1;

    typedef struct packed {
        logic [OPER_W-1:0] operand_a;
        logic [OPER_W-1:0] operand_b;
        logic [GCD_W-1:0]  gcd_value;
        logic [LCM_W-1:0]  lcm_value;
        logic              lcm_undefined;
    } t_divisor_multiple;

    t_divisor_multiple awaited_results[$];

    // Euclid on the masked operands; the multiple is (a / g) * b, which cannot overflow.
    function automatic t_divisor_multiple gcd_lcm_of(input logic [OPER_W-1:0] raw_a,
                                                     input logic [OPER_W-1:0] raw_b);
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] x;
        logic [63:0] y;
        logic [63:0] rem;
        t_divisor_multiple res;
        a = {32'd0, raw_a} & OPERAND_MASK;
        b = {32'd0, raw_b} & OPERAND_MASK;
        x = a;
        y = b;
        while (y != 64'd0) begin
            rem = x % y;
            x = y;
            y = rem;
        end
        res.operand_a     = raw_a;
        res.operand_b     = raw_b;
        res.gcd_value     = x[GCD_W-1:0];
        res.lcm_undefined = (x == 64'd0);
        res.lcm_value     = (x == 64'd0) ? '0 : (a / x) * b;
        return res;
    endfunction

    task automatic note_failure(input string what);
        o_fail_count++;
        if (o_fail_count <= REPORT_LIMIT) begin
            $display("%0d ns: %s", $time, what);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_divisor_multiple want;
        logic [GCD_W-1:0] got_gcd;
        logic [LCM_W-1:0] got_lcm;
        logic             got_undef;
        if (!i_rst_n) begin
            awaited_results.delete();
            o_fail_count = 0;
        end else begin
            // Take the result first: it can only belong to an older item.
            if (i_m_tvalid && i_m_tready) begin
                got_gcd   = i_m_tdata[31:0];
                got_lcm   = i_m_tdata[95:32];
                got_undef = i_m_tuser[0];
                if (awaited_results.size() == 0) begin
                    note_failure($sformatf("result with nothing awaited: gcd=%h lcm=%h undef=%b",
                                           got_gcd, got_lcm, got_undef));
                end else begin
                    want = awaited_results.pop_front();
                    if (got_gcd !== want.gcd_value || got_lcm !== want.lcm_value ||
                        got_undef !== want.lcm_undefined) begin
                        note_failure($sformatf("a=%h b=%h: expected gcd=%h lcm=%h undef=%b, %s",
                            want.operand_a, want.operand_b, want.gcd_value, want.lcm_value,
                            want.lcm_undefined,
                            $sformatf("got gcd=%h lcm=%h undef=%b", got_gcd, got_lcm, got_undef)));
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                awaited_results.push_back(gcd_lcm_of(i_s_tdata[31:0], i_s_tdata[63:32]));
            end
        end
        o_pending = awaited_results.size();
    end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// Top of the GCD/LCM unit testbench: clock, reset, operand stimulus, receiver stalls, verdict.
module testbench;
    import glu_pkg::*;

    localparam int unsigned DUT_WIDTH    = 32;
    localparam int unsigned RESET_CYCLES = 7;
    localparam int unsigned RANDOM_ITEMS = 800;
    localparam int unsigned HOLD_CYCLES  = 3000;
    localparam int unsigned IDLE_LIMIT   = 40000;
    localparam int unsigned DRAIN_CYCLES = 200;

    typedef enum int {
        RX_OPEN,
        RX_MOSTLY,
        RX_SPARSE,
        RX_PERIODIC
    } t_rx_mode;

    typedef enum int {
        OPS_FULL,
        OPS_SHARED,
        OPS_NARROW,
        OPS_ONE_ZERO,
        OPS_EQUAL,
        OPS_FIBONACCI
    } t_operand_kind;

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [63:0] s_tdata  = '0;   // [31:0] operand_a, [63:32] operand_b
    logic        m_tready = 1'b0;
    wire logic        s_tready;
    wire logic        m_tvalid;
    wire logic [95:0] m_tdata;    // [31:0] gcd_value, [95:32] lcm_value
    wire logic [0:0]  m_tuser;    // [0] lcm_undefined

    int fail_count;
    int pending;
    int idle_cycles = 0;
    int burst_left  = 0;
    bit hold_request = 1'b0;

    gcd_lcm_unit #(
        .WIDTH(DUT_WIDTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    gcd_lcm_checker #(
        .WIDTH(DUT_WIDTH)
    ) u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT) begin
                    $display("FAILURE");
                    $finish;
                end
            end
        end
    end

    // Receiver: change stall pattern after a random span; hold off on request.
    initial begin : receiver
        t_rx_mode mode;
        int       span;
        int       tick;
        bit       hold_now;
        tick = 0;
        forever begin
            mode = t_rx_mode'($urandom_range(0, 3));
            span = $urandom_range(32, 256);
            repeat (span) begin
                @(posedge i_clk);
                hold_now = hold_request;
                @(negedge i_clk);
                if (hold_now) begin
                    m_tready <= 1'b0;
                    repeat (HOLD_CYCLES) @(negedge i_clk);
                    hold_request = 1'b0;
                end
                case (mode)
                    RX_OPEN:   m_tready <= 1'b1;
                    RX_MOSTLY: m_tready <= ($urandom_range(0, 3) != 0);
                    RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
                    default:   m_tready <= (tick % 5 != 0);
                endcase
                tick++;
            end
        end
    end

    // Offer one item at a falling edge; return at a later one once taken and after any idle gap.
    task automatic offer(input logic [31:0] a, input logic [31:0] b);
        s_tvalid <= 1'b1;
        s_tdata  <= {b, a};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        @(negedge i_clk);
        burst_left--;
        if (burst_left <= 0) begin
            s_tvalid <= 1'b0;
            s_tdata  <= {$urandom, $urandom};
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
            burst_left = $urandom_range(1, 40);
        end
    endtask

    // Stop offering until every awaited result has been taken.
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
    endtask

    initial begin : stimulus
        t_operand_kind kind;
        logic [31:0]   a;
        logic [31:0]   b;
        logic [31:0]   factor;
        logic [63:0]   fib_x;
        logic [63:0]   fib_y;
        logic [63:0]   fib_t;
        int            pick;
        int            bits;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        burst_left = $urandom_range(1, 40);
        @(negedge i_clk);

        // Zero operands, extremes, swapped order, worst-case Euclid chain, large primes.
        offer(32'h0000_0000, 32'h0000_0000);
        offer(32'hFFFF_FFFF, 32'h0000_0000);
        offer(32'h0000_0000, 32'hFFFF_FFFF);
        offer(32'h0000_0000, 32'h0000_0001);
        offer(32'h0000_0001, 32'h0000_0000);
        offer(32'h0000_0001, 32'h0000_0001);
        offer(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        offer(32'hFFFF_FFFF, 32'h0000_0001);
        offer(32'h0000_0001, 32'hFFFF_FFFF);
        offer(32'hFFFF_FFFF, 32'hFFFF_FFFE);
        offer(32'h8000_0000, 32'h8000_0000);
        offer(32'h8000_0000, 32'h0000_0001);
        offer(32'd12, 32'd18);
        offer(32'd18, 32'd12);
        offer(32'd2971215073, 32'd1836311903);
        offer(32'd4294967291, 32'd4294967279);
        offer(32'h0001_0000, 32'h0000_0100);
        offer(32'hFFFF_0000, 32'h0000_FFFF);
        offer(32'd6, 32'd35);
        offer(32'hAAAA_AAAA, 32'h5555_5555);
        offer(32'd7, 32'd7);
        wait_for_results();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 250 || n == 600) begin
                hold_request = 1'b1;
            end
            if (n == 450) begin
                wait_for_results();
            end
            pick = $urandom_range(0, 99);
            if (pick < 40)      kind = OPS_FULL;
            else if (pick < 65) kind = OPS_SHARED;
            else if (pick < 82) kind = OPS_NARROW;
            else if (pick < 90) kind = OPS_ONE_ZERO;
            else if (pick < 97) kind = OPS_EQUAL;
            else                kind = OPS_FIBONACCI;
            a = $urandom;
            b = $urandom;
            case (kind)
                OPS_SHARED: begin
                    factor = $urandom_range(1, 65536);
                    a = factor * $urandom_range(0, 65535);
                    b = factor * $urandom_range(0, 65535);
                end
                OPS_NARROW: begin
                    bits = $urandom_range(1, 32);
                    a = a & 32'((64'd1 << bits) - 64'd1);
                    bits = $urandom_range(1, 32);
                    b = b & 32'((64'd1 << bits) - 64'd1);
                end
                OPS_ONE_ZERO: begin
                    if ($urandom_range(0, 1) == 0) a = '0;
                    else                           b = '0;
                end
                OPS_EQUAL: begin
                    b = a;
                end
                OPS_FIBONACCI: begin
                    // Adjacent Fibonacci numbers give the longest remainder chain.
                    fib_x = 64'd1;
                    fib_y = 64'd1;
                    repeat ($urandom_range(1, 45)) begin
                        fib_t = fib_x + fib_y;
                        fib_x = fib_y;
                        fib_y = fib_t;
                    end
                    if ($urandom_range(0, 1) == 0) begin
                        a = fib_y[31:0];
                        b = fib_x[31:0];
                    end else begin
                        a = fib_x[31:0];
                        b = fib_y[31:0];
                    end
                end
                default: begin
                end
            endcase
            offer(a, b);
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/glu_pkg.sv
rtl/glu_seq.sv
rtl/glu_dp.sv
rtl/gcd_lcm_unit.sv
dv/gcd_lcm_checker.sv
dv/testbench.sv
